### src/bmg_pkg.sv
// Shared constants, types and constant functions for the Box-Muller sample core.
package bmg_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int LOG_FRAC         = 24;
  localparam int SQRT_STEPS       = 19;
  localparam int CNT_W            = 5;
  localparam int CFG_ADDR_W       = 1;
  localparam int CFG_DATA_W       = 16;
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

  localparam logic [CFG_ADDR_W-1:0] REG_MEAN    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STD_DEV = 1'd1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOG  = 8'b0000_0010,
    ST_LSCL = 8'b0000_0100,
    ST_SQRT = 8'b0000_1000,
    ST_CORD = 8'b0001_0000,
    ST_SIN  = 8'b0010_0000,
    ST_COS  = 8'b0100_0000,
    ST_SCL  = 8'b1000_0000
  } bmg_state_t;

  // log2 in Q.24 by repeated squaring, for elaboration only
  function automatic logic [63:0] log2_fix_c(input logic [15:0] v);
    int e;
    logic [63:0] m;
    logic [63:0] f;
    e = 0;
    for (int k = 1; k < 16; k++) begin
      if ((v >> k) != 16'd0) e = k;
    end
    m = {48'd0, v} << (30 - e);
    f = 64'd0;
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f = f | 64'd1;
      end
    end
    return (64'(e) << LOG_FRAC) | f;
  endfunction

  localparam logic [28:0] LOG2_MAX = 29'(log2_fix_c(16'hFFFF));

  // starting x of the rotation: 2^60 / gain, gain in Q30
  function automatic logic [32:0] cordic_x0(input int steps);
    logic [63:0] p;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    logic [63:0] q;
    p = 64'd1 << 30;
    for (int i = 0; i < steps; i++) p = p + (p >> (2 * i));
    n = p << 30;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    rem = 64'd0;
    q = 64'd0;
    for (int k = 60; k >= 0; k--) begin
      rem = (rem << 1) | ((k == 60) ? 64'd1 : 64'd0);
      if (rem >= r) begin
        rem = rem - r;
        q = q | (64'd1 << k);
      end
    end
    return 33'(q);
  endfunction

  function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // round product to Q4.12 and saturate
  function automatic logic signed [15:0] to_q412(input logic signed [67:0] p);
    logic signed [67:0] t;
    logic signed [15:0] d;
    t = (p + (68'sd1 <<< 33)) >>> 34;
    if (t > 68'sd32767) d = 16'sh7FFF;
    else if (t < -68'sd32768) d = 16'sh8000;
    else d = t[15:0];
    return d;
  endfunction

endpackage

### src/box_muller_gaussian_sample_core.sv
// Box-Muller Gaussian sample core: sequenced log, sqrt and CORDIC with one shared multiplier.
// A fresh pair runs log, log scale, sqrt, CORDIC, sine and cosine products, then output scale;
// a held deviate goes straight to the output scale. in_tready is high only in idle.
// Each transaction yields one sample; the next is taken in idle while the result waits.
// The 24 log squarings, the scale and the final products share one multiplier.
// rst_n is synchronous, active low: mean 0, std_dev 1.0, no deviate held.
module box_muller_gaussian_sample_core #(
  parameter int CORDIC_STEPS = bmg_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] uniform_dist, [31:16] uniform_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sample
  output logic        out_tuser,  // [0] from_store
  input  logic        cfg_we,
  input  logic [bmg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bmg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [32:0] X0 = bmg_pkg::cordic_x0(CORDIC_STEPS);
  localparam int CW = bmg_pkg::CNT_W;

  bmg_pkg::bmg_state_t state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [30:0]         m_r, m_nxt;
  logic [3:0]          e_r, e_nxt;
  logic [23:0]         f_r, f_nxt;
  logic [37:0]         sq_n_r, sq_n_nxt;
  logic [20:0]         rem_r, rem_nxt;
  logic [18:0]         root_r, root_nxt;
  logic [15:0]         v2_r, v2_nxt;
  logic signed [32:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0]  z_r, z_nxt;
  logic signed [15:0]  dev_r, dev_nxt, held_dev_r, held_dev_nxt;
  logic                held_valid_r, held_valid_nxt, from_r, from_nxt;
  logic [15:0]         mean_r, std_r;
  logic [31:0]         out_data_r, out_data_nxt;
  logic                out_user_r, out_user_nxt, out_valid_r, out_valid_nxt;

  logic signed [33:0]  mul_a, mul_b;
  logic signed [67:0]  prod;
  logic [15:0]         v1;
  logic [3:0]          e_in;
  logic [31:0]         sq;
  logic signed [29:0]  dlog;
  logic [28:0]         dcl;
  logic [67:0]         lsum;
  logic [20:0]         rem_t, trial;
  logic [31:0]         phase;
  logic signed [33:0]  cc, ss;
  logic signed [32:0]  xs, ys;
  logic signed [39:0]  ps, tot;
  logic [31:0]         sample;
  logic                in_acc, out_free;

  assign in_tready  = (state_r == bmg_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // radius draw of zero is taken as full scale
  assign v1 = (in_tdata[15:0] == 16'd0) ? 16'hFFFF : in_tdata[15:0];

  always_comb begin
    e_in = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (v1[k]) e_in = 4'(k);
    end
  end

  assign dlog  = $signed({1'b0, bmg_pkg::LOG2_MAX}) - $signed({1'b0, e_r, f_r[23:0]} & 30'h1FFFFFFF);
  assign dcl   = dlog[29] ? 29'd0 : dlog[28:0];
  assign phase = {v2_r, v2_r} + {31'd0, v2_r[15]};

  always_comb begin
    unique case (phase[31:30])
      2'd0: begin cc = 34'(x_r);  ss = 34'(y_r);  end
      2'd1: begin cc = -34'(y_r); ss = 34'(x_r);  end
      2'd2: begin cc = -34'(x_r); ss = -34'(y_r); end
      default: begin cc = 34'(y_r); ss = -34'(x_r); end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      bmg_pkg::ST_LOG: begin
        mul_a = $signed({3'd0, m_r});
        mul_b = $signed({3'd0, m_r});
      end
      bmg_pkg::ST_LSCL: begin
        mul_a = $signed({5'd0, dcl});
        mul_b = $signed({3'd0, bmg_pkg::TWO_LN2_Q30});
      end
      bmg_pkg::ST_SIN: begin
        mul_a = $signed({15'd0, root_r});
        mul_b = ss;
      end
      bmg_pkg::ST_COS: begin
        mul_a = $signed({15'd0, root_r});
        mul_b = cc;
      end
      bmg_pkg::ST_SCL: begin
        mul_a = 34'(dev_r);
        mul_b = $signed({18'd0, std_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign sq    = prod[61:30];
  assign lsum  = prod + (68'd1 << 29);
  assign rem_t = {rem_r[18:0], sq_n_r[37:36]};
  assign trial = {root_r, 2'b01};
  assign xs    = x_r >>> cnt_r;
  assign ys    = y_r >>> cnt_r;
  assign ps    = ($signed(prod[39:0]) + 40'sd8) >>> 4;
  assign tot   = ps + (40'(signed'(mean_r)) <<< 8);
  assign sample = (tot > 40'sd2147483647) ? 32'h7FFFFFFF :
                  (tot < -40'sd2147483648) ? 32'h80000000 : tot[31:0];

  always_comb begin
    state_nxt = state_r;  cnt_nxt = cnt_r;  m_nxt = m_r;  e_nxt = e_r;  f_nxt = f_r;
    sq_n_nxt = sq_n_r;  rem_nxt = rem_r;  root_nxt = root_r;  v2_nxt = v2_r;
    x_nxt = x_r;  y_nxt = y_r;  z_nxt = z_r;  dev_nxt = dev_r;
    held_dev_nxt = held_dev_r;  held_valid_nxt = held_valid_r;  from_nxt = from_r;
    out_data_nxt = out_data_r;  out_user_nxt = out_user_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      bmg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (held_valid_r) begin
            dev_nxt        = held_dev_r;
            from_nxt       = 1'b1;
            held_valid_nxt = 1'b0;
            state_nxt      = bmg_pkg::ST_SCL;
          end else begin
            from_nxt  = 1'b0;
            e_nxt     = e_in;
            m_nxt     = {15'd0, v1} << (5'd30 - {1'b0, e_in});
            f_nxt     = '0;
            v2_nxt    = in_tdata[31:16];
            cnt_nxt   = '0;
            state_nxt = bmg_pkg::ST_LOG;
          end
        end
      end
      bmg_pkg::ST_LOG: begin
        if (sq[31]) begin
          m_nxt = sq[31:1];
          f_nxt = {f_r[22:0], 1'b1};
        end else begin
          m_nxt = sq[30:0];
          f_nxt = {f_r[22:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(bmg_pkg::LOG_FRAC - 1)) state_nxt = bmg_pkg::ST_LSCL;
      end
      bmg_pkg::ST_LSCL: begin
        sq_n_nxt  = {1'b0, lsum[58:30], 8'd0};
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = bmg_pkg::ST_SQRT;
      end
      bmg_pkg::ST_SQRT: begin
        sq_n_nxt = {sq_n_r[35:0], 2'b00};
        if (rem_t >= trial) begin
          rem_nxt  = rem_t - trial;
          root_nxt = {root_r[17:0], 1'b1};
        end else begin
          rem_nxt  = rem_t;
          root_nxt = {root_r[17:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(bmg_pkg::SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          x_nxt     = $signed(X0);
          y_nxt     = '0;
          z_nxt     = $signed({2'b00, phase[29:0]});
          state_nxt = bmg_pkg::ST_CORD;
        end
      end
      bmg_pkg::ST_CORD: begin
        if (!z_r[31]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - $signed(bmg_pkg::atan_turn(cnt_r));
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + $signed(bmg_pkg::atan_turn(cnt_r));
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(CORDIC_STEPS - 1)) state_nxt = bmg_pkg::ST_SIN;
      end
      bmg_pkg::ST_SIN: begin
        dev_nxt   = bmg_pkg::to_q412(prod);
        state_nxt = bmg_pkg::ST_COS;
      end
      bmg_pkg::ST_COS: begin
        held_dev_nxt   = bmg_pkg::to_q412(prod);
        held_valid_nxt = 1'b1;
        state_nxt      = bmg_pkg::ST_SCL;
      end
      bmg_pkg::ST_SCL: begin
        // hold here until the output register is free
        if (out_free) begin
          out_data_nxt  = sample;
          out_user_nxt  = from_r;
          out_valid_nxt = 1'b1;
          state_nxt     = bmg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bmg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bmg_pkg::ST_IDLE;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      mean_r       <= 16'd0;
      std_r        <= 16'd256;
    end else begin
      state_r      <= state_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          bmg_pkg::REG_MEAN:    mean_r <= cfg_wdata;
          bmg_pkg::REG_STD_DEV: std_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    m_r        <= m_nxt;
    e_r        <= e_nxt;
    f_r        <= f_nxt;
    sq_n_r     <= sq_n_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    v2_r       <= v2_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    dev_r      <= dev_nxt;
    held_dev_r <= held_dev_nxt;
    from_r     <= from_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

### src/bmg_checker.sv
// Port-level checks for the Box-Muller sample core, bound to the top level.
module bmg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // in_tready drops after every accepted transaction, fresh pair or held deviate
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("transaction taken while busy");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind box_muller_gaussian_sample_core bmg_checker u_bmg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

### test/testbench.sv
// Self-checking testbench for the Box-Muller Gaussian sample core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = bmg_pkg::CORDIC_STEPS_DEF;
  localparam int N_RANDOM = 1400;

  typedef struct packed {
    logic [15:0] angle_draw;
    logic [15:0] radius_draw;
  } draw_t;

  typedef struct packed {
    logic        from_store;
    logic [31:0] sample;
  } sample_t;

  typedef struct {
    logic        cfg_write;
    logic [bmg_pkg::CFG_ADDR_W-1:0] reg_idx;
    logic [15:0] reg_val;
    logic [15:0] radius_draw;
    logic [15:0] angle_draw;
    logic        typed;
    logic [31:0] typed_sample;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we;
  logic [bmg_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [bmg_pkg::CFG_DATA_W-1:0] cfg_wdata;

  box_muller_gaussian_sample_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [15:0] mdl_mean;
  logic [15:0] mdl_scale;
  logic        mdl_held;
  logic signed [15:0] mdl_held_dev;

  sample_t expected_samples[$];
  int errors;
  int n_sent, n_seen, n_from_store, n_sat;
  bit long_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint sar(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint unsigned log2_q24(logic [15:0] v);
    int e;
    longint unsigned m;
    longint unsigned f;
    e = 0;
    while (e < 15 && (v >> (e + 1)) != 0) e++;
    m = longint'(v) << (30 - e);
    f = 0;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    return (longint'(e) << 24) | f;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] round_dev(logic signed [127:0] p);
    logic signed [127:0] t;
    t = (p + (128'sd1 <<< 33)) >>> 34;
    if (t > 128'sd32767) return 16'sh7FFF;
    if (t < -128'sd32768) return 16'sh8000;
    return t[15:0];
  endfunction

  function automatic logic [31:0] scaled(logic signed [15:0] dev);
    longint p;
    p = sar(longint'(dev) * longint'({1'b0, mdl_scale}) + 8, 4);
    p = p + longint'($signed(mdl_mean)) * 256;
    if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
    if (p < -64'sh8000_0000) p = -64'sh8000_0000;
    return p[31:0];
  endfunction

  function automatic sample_t gaussian_next(logic [15:0] rd, logic [15:0] ad);
    sample_t r;
    logic signed [15:0] dev;
    longint d, x, y, z, t, c, s;
    longint unsigned l, radius, p, g, ph;
    logic [31:0] phase;
    logic [1:0] quad;
    if (mdl_held) begin
      dev = mdl_held_dev;
      mdl_held = 1'b0;
      r.from_store = 1'b1;
    end else begin
      if (rd == 0) rd = 16'hFFFF;
      d = longint'(log2_q24(16'hFFFF)) - longint'(log2_q24(rd));
      if (d < 0) d = 0;
      l = (longint'(d) * 64'd1488522236 + (64'd1 << 29)) >> 30;
      radius = root64(l << 8);
      ph = ((longint'(ad) << 32) + 32767) / 65535;
      phase = ph[31:0];
      quad = phase[31:30];
      p = 64'd1 << 30;
      for (int i = 0; i < STEPS; i++) p = p + (p >> (2 * i));
      g = root64(p << 30);
      x = longint'((64'd1 << 60) / g);
      y = 0;
      z = longint'(phase[29:0]);
      for (int i = 0; i < STEPS; i++) begin
        if (z >= 0) begin
          t = x - sar(y, i);
          y = y + sar(x, i);
          z = z - longint'(bmg_pkg::atan_turn(i[4:0]));
        end else begin
          t = x + sar(y, i);
          y = y - sar(x, i);
          z = z + longint'(bmg_pkg::atan_turn(i[4:0]));
        end
        x = t;
      end
      case (quad)
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      dev = round_dev(128'(signed'({1'b0, radius})) * 128'(s));
      mdl_held_dev = round_dev(128'(signed'({1'b0, radius})) * 128'(c));
      mdl_held = 1'b1;
      r.from_store = 1'b0;
    end
    r.sample = scaled(dev);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s at %0t: got %h, expected %h", what, $realtime, got, want);
  endtask

  // result side: stalls on a pattern, one long hold-off on request
  initial begin
    int hold;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        hold = 0;
        while (hold < 400) begin
          @(posedge clk);
          hold++;
        end
        long_hold = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ~out_tready;
        default: out_tready <= ($urandom_range(0, 1) == 1);
      endcase
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_seen++;
      if (out_tuser) n_from_store++;
      if (out_tdata == 32'h7FFF_FFFF || out_tdata == 32'h8000_0000) n_sat++;
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected sample", out_tdata, 32'h0);
      end else begin
        want = expected_samples.pop_front();
        if (out_tdata !== want.sample) report_mismatch("sample", out_tdata, want.sample);
        if (out_tuser !== want.from_store)
          report_mismatch("from_store", {31'd0, out_tuser}, {31'd0, want.from_store});
      end
    end
  end

  task automatic write_reg(logic [bmg_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == bmg_pkg::REG_MEAN) mdl_mean = val;
    else if (idx == bmg_pkg::REG_STD_DEV) mdl_scale = val;
  endtask

  task automatic drain();
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // offers one transaction; with keep_valid, valid stays high between back-to-back items
  task automatic send_draw(logic [15:0] rd, logic [15:0] ad, bit keep_valid);
    draw_t dw;
    dw.radius_draw = rd;
    dw.angle_draw = ad;
    in_tvalid <= 1'b1;
    in_tdata <= dw;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_samples.push_back(gaussian_next(rd, ad));
    n_sent++;
    if (!keep_valid) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  stim_row_t rows[$];

  function automatic stim_row_t draw_row(logic [15:0] rd, logic [15:0] ad);
    stim_row_t r;
    r = '{1'b0, '0, 16'd0, rd, ad, 1'b0, 32'd0};
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [15:0] rd, logic [15:0] ad, logic [31:0] s);
    stim_row_t r;
    r = '{1'b0, '0, 16'd0, rd, ad, 1'b1, s};
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [bmg_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] v);
    stim_row_t r;
    r = '{1'b1, idx, v, 16'd0, 16'd0, 1'b0, 32'd0};
    return r;
  endfunction

  initial begin
    int burst, gap, i, n;
    sample_t chk;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    errors = 0;
    n_sent = 0; n_seen = 0; n_from_store = 0; n_sat = 0;
    long_hold = 1'b0;
    mdl_mean = 16'd0;
    mdl_scale = 16'd256;
    mdl_held = 1'b0;
    mdl_held_dev = 16'sd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // u1 = 1 gives radius 0: both deviates are zero, so sample = mean
    rows.push_back(typed_row(16'hFFFF, 16'h1234, 32'd0));
    rows.push_back(typed_row(16'hABCD, 16'h5555, 32'd0));
    // zero radius draw counts as one
    rows.push_back(typed_row(16'h0000, 16'hFFFF, 32'd0));
    rows.push_back(typed_row(16'h0000, 16'h0000, 32'd0));
    rows.push_back(draw_row(16'h0001, 16'h0000));
    rows.push_back(draw_row(16'h0001, 16'h0000));
    rows.push_back(draw_row(16'h0001, 16'h4000));
    rows.push_back(draw_row(16'h0001, 16'h8000));
    rows.push_back(draw_row(16'h0001, 16'hFFFF));
    rows.push_back(draw_row(16'h0001, 16'hC000));
    rows.push_back(reg_row(bmg_pkg::REG_MEAN, 16'h7FFF));
    rows.push_back(reg_row(bmg_pkg::REG_STD_DEV, 16'hFFFF));
    rows.push_back(typed_row(16'hFFFF, 16'h0000, 32'h007F_FF00));
    rows.push_back(typed_row(16'h0000, 16'h0000, 32'h007F_FF00));
    rows.push_back(draw_row(16'h0001, 16'h2000));
    rows.push_back(draw_row(16'h0002, 16'hE000));
    rows.push_back(reg_row(bmg_pkg::REG_MEAN, 16'h8000));
    rows.push_back(typed_row(16'hFFFF, 16'h0000, 32'hFF80_0000));
    rows.push_back(typed_row(16'hFFFF, 16'h0000, 32'hFF80_0000));
    rows.push_back(draw_row(16'h0001, 16'h6000));
    rows.push_back(reg_row(bmg_pkg::REG_STD_DEV, 16'h0000));
    rows.push_back(draw_row(16'h7FFF, 16'hAAAA));
    rows.push_back(draw_row(16'h8000, 16'h5555));

    foreach (rows[k]) begin
      if (rows[k].cfg_write) begin
        drain();
        write_reg(rows[k].reg_idx, rows[k].reg_val);
      end else begin
        send_draw(rows[k].radius_draw, rows[k].angle_draw, 1'b0);
        if (rows[k].typed) begin
          chk = expected_samples[$];
          if (chk.sample !== rows[k].typed_sample)
            report_mismatch("predictor vs table", chk.sample, rows[k].typed_sample);
        end
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(bmg_pkg::REG_MEAN, 16'd0);
          write_reg(bmg_pkg::REG_STD_DEV, 16'd256);
        end
        1: begin
          write_reg(bmg_pkg::REG_MEAN, 16'h7FFF);
          write_reg(bmg_pkg::REG_STD_DEV, 16'hFFFF);
        end
        2: begin
          write_reg(bmg_pkg::REG_MEAN, 16'h8000);
          write_reg(bmg_pkg::REG_STD_DEV, 16'hFFFF);
        end
        3: begin
          write_reg(bmg_pkg::REG_MEAN, 16'd0);
          write_reg(bmg_pkg::REG_STD_DEV, 16'd0);
        end
        default: begin
          write_reg(bmg_pkg::REG_MEAN, 16'($urandom));
          write_reg(bmg_pkg::REG_STD_DEV, 16'($urandom));
        end
      endcase
      n = N_RANDOM / 7;
      i = 0;
      while (i < n) begin
        burst = $urandom_range(1, 12);
        if (ph == 1 && i == 20) long_hold = 1'b1;
        for (int b = 0; b < burst && i < n; b++) begin
          // most draws random, some near the large-radius corner
          send_draw(($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom),
                    16'($urandom), (b + 1 < burst) && (i + 1 < n));
          i++;
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        repeat (gap) @(posedge clk);
      end
    end

    drain();
    $display("Covered %0d draws: %0d samples, %0d from the held deviate, %0d saturated.",
             n_sent, n_seen, n_from_store, n_sat);
    $display("Register settings included mean and std_dev extremes and a long output stall.");
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
